>>> sv/isa_pkg.sv
// shared types, constants and codes for the interval slot alu
package isa_pkg;

  localparam int FIELD_W         = 64;
  localparam int HALF_W          = FIELD_W / 2;
  localparam int WIDE_W          = 2 * FIELD_W;
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int KIND_W          = 3;
  localparam int SCALE_W         = 6;
  localparam int ERR_W           = 32;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_INDEX_W     = 1;
  localparam int LANES           = 5;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(20);
  localparam logic [ERR_W-1:0]   ERR_RESET   = '0;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD          = 3'd0,
    KIND_ADD_CONST    = 3'd1,
    KIND_MUL          = 3'd2,
    KIND_SQUARE       = 3'd3,
    KIND_MUL_CONST_RS = 3'd4,
    KIND_MUL_CONST    = 3'd5
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCALE_LOG2    = 1'b0,
    REG_RESCALE_ERROR = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] a_nominal;
    logic signed [FIELD_W-1:0] a_upper;
    logic signed [FIELD_W-1:0] a_lower;
    logic signed [FIELD_W-1:0] b_nominal;
    logic signed [FIELD_W-1:0] b_upper;
    logic signed [FIELD_W-1:0] b_lower;
    logic signed [FIELD_W-1:0] scalar;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] res_nominal;
    logic signed [FIELD_W-1:0] res_upper;
    logic signed [FIELD_W-1:0] res_lower;
    logic                      saturated;
  } res_t;

  typedef struct packed {
    logic pp;
    logic mid;
    logic sum;
  } mul_en_t;

endpackage

>>> sv/isa_mul.sv
// three-stage signed 64x64 multiplier built from 32-bit partial products
module isa_mul (
  input  logic                                  clk,
  input  isa_pkg::mul_en_t                      en,
  input  logic signed [isa_pkg::FIELD_W-1:0]    x,
  input  logic signed [isa_pkg::FIELD_W-1:0]    y,
  output logic signed [isa_pkg::WIDE_W-1:0]     prod
);

  logic        [isa_pkg::FIELD_W-1:0]   pp_ll, pp_ll_next;
  logic signed [isa_pkg::FIELD_W:0]     pp_lh, pp_lh_next;
  logic signed [isa_pkg::FIELD_W:0]     pp_hl, pp_hl_next;
  logic signed [isa_pkg::FIELD_W-1:0]   pp_hh, pp_hh_next;
  logic        [isa_pkg::FIELD_W+1:0]   mid, mid_next;
  logic        [isa_pkg::WIDE_W-1:0]    cat, cat_next;
  logic        [isa_pkg::WIDE_W-1:0]    prod_next;

  always_comb begin
    pp_ll_next = x[isa_pkg::HALF_W-1:0] * y[isa_pkg::HALF_W-1:0];
    pp_lh_next = $signed({1'b0, x[isa_pkg::HALF_W-1:0]})
               * $signed(y[isa_pkg::FIELD_W-1:isa_pkg::HALF_W]);
    pp_hl_next = $signed(x[isa_pkg::FIELD_W-1:isa_pkg::HALF_W])
               * $signed({1'b0, y[isa_pkg::HALF_W-1:0]});
    pp_hh_next = $signed(x[isa_pkg::FIELD_W-1:isa_pkg::HALF_W])
               * $signed(y[isa_pkg::FIELD_W-1:isa_pkg::HALF_W]);
  end

  always_comb begin
    mid_next = {pp_lh[isa_pkg::FIELD_W], pp_lh} + {pp_hl[isa_pkg::FIELD_W], pp_hl};
    cat_next = {pp_hh, pp_ll};
  end

  always_comb begin
    prod_next = cat
              + {{(isa_pkg::WIDE_W - isa_pkg::FIELD_W - 2 - isa_pkg::HALF_W)
                  {mid[isa_pkg::FIELD_W+1]}}, mid, {isa_pkg::HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en.pp) begin
      pp_ll <= pp_ll_next;
      pp_lh <= pp_lh_next;
      pp_hl <= pp_hl_next;
      pp_hh <= pp_hh_next;
    end
    if (en.mid) begin
      mid <= mid_next;
      cat <= cat_next;
    end
    if (en.sum) begin
      prod <= $signed(prod_next);
    end
  end

endmodule

>>> sv/interval_slot_alu_top.sv
// interval slot alu top level: operand select, multiply lanes, bound merge, rescale, saturate
// each accepted transaction passes through ten register stages, stage 0 to stage 9, before its result is valid
// throughput: one transaction per cycle while req_stall is low, set by the fully pipelined multiply lanes
// a stalled result holds only the unbroken run of full stages behind it; earlier stages keep filling
// reset clears all valid bits and sets scale_log2 to 20 and rescale_error to 0
// payload registers are not reset
module interval_slot_alu_top #(
  parameter int VALUE_WIDTH = isa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [isa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [isa_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  isa_pkg::req_t                       req,
  output logic                                res_valid,
  input  logic                                res_stall,
  output isa_pkg::res_t                       res
);

  localparam int NST = 10;
  localparam int FW  = isa_pkg::FIELD_W;
  localparam int WW  = isa_pkg::WIDE_W;
  localparam logic signed [WW-1:0] SAT_MAX =
    {{(WW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [WW-1:0] SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic [isa_pkg::KIND_W-1:0] kind;
    logic                       straddle;
    logic                       sc_neg;
    logic [FW:0]                sum_n;
    logic [FW:0]                sum_u;
    logic [FW:0]                sum_l;
  } side_t;

  typedef struct packed {
    logic signed [WW-1:0] n;
    logic signed [WW-1:0] u;
    logic signed [WW-1:0] l;
  } trio_t;

  function automatic logic signed [WW-1:0] wmax(input logic signed [WW-1:0] a,
                                                input logic signed [WW-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic signed [WW-1:0] wmin(input logic signed [WW-1:0] a,
                                                input logic signed [WW-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [WW-1:0] wsat(input logic signed [WW-1:0] a);
    if (a > SAT_MAX) begin
      return SAT_MAX;
    end else if (a < SAT_MIN) begin
      return SAT_MIN;
    end
    return a;
  endfunction

  function automatic logic out_of_range(input logic signed [WW-1:0] a);
    return (a > SAT_MAX) || (a < SAT_MIN);
  endfunction

  logic [isa_pkg::SCALE_W-1:0] scale_log2;
  logic [isa_pkg::ERR_W-1:0]   rescale_error;

  logic [NST-1:0] v;
  logic [NST-1:0] rdy;

  isa_pkg::req_t s0_req;

  logic signed [FW-1:0] mx [isa_pkg::LANES];
  logic signed [FW-1:0] my [isa_pkg::LANES];
  logic signed [WW-1:0] prod [isa_pkg::LANES];
  isa_pkg::mul_en_t     mul_en;

  side_t side_next;
  side_t side [1:5];

  logic signed [WW-1:0] hi12, hi12_next, lo12, lo12_next;
  logic signed [WW-1:0] mx34, mx34_next, mn34, mn34_next;
  logic signed [WW-1:0] nom4;
  logic signed [WW-1:0] up5, up5_next, lo5, lo5_next, nom5;

  trio_t s6, s6_next, s7, s7_next, s8, s8_next;
  logic  rs6, rs6_next, rs7;
  isa_pkg::res_t res_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_log2    <= isa_pkg::SCALE_RESET;
      rescale_error <= isa_pkg::ERR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        isa_pkg::REG_SCALE_LOG2:    scale_log2    <= cfg_wr_data[isa_pkg::SCALE_W-1:0];
        isa_pkg::REG_RESCALE_ERROR: rescale_error <= cfg_wr_data[isa_pkg::ERR_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it or any stage after it is empty, or the output moves
  always_comb begin
    for (int i = 0; i < NST; i++) begin
      rdy[i] = !res_stall || !(&(v | NST'((1 << i) - 1)));
    end
  end

  assign req_stall = !rdy[0];
  assign res_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~rdy) | ({v[NST-2:0], req_valid} & rdy);
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_req <= req;
    end
  end

  // operand select for the multiply lanes
  always_comb begin
    mx[0] = s0_req.a_nominal;
    mx[1] = s0_req.a_upper;
    mx[2] = s0_req.a_lower;
    mx[3] = s0_req.a_lower;
    mx[4] = s0_req.a_lower;
    my[0] = s0_req.scalar;
    my[1] = s0_req.scalar;
    my[2] = s0_req.scalar;
    my[3] = s0_req.b_upper;
    my[4] = s0_req.b_lower;
    case (s0_req.kind)
      isa_pkg::KIND_MUL: begin
        mx[2] = s0_req.a_upper;
        my[0] = s0_req.b_nominal;
        my[1] = s0_req.b_upper;
        my[2] = s0_req.b_lower;
      end
      isa_pkg::KIND_SQUARE: begin
        my[0] = s0_req.a_nominal;
        my[1] = s0_req.a_upper;
        my[2] = s0_req.a_lower;
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_en.pp  = rdy[1];
    mul_en.mid = rdy[2];
    mul_en.sum = rdy[3];
  end

  for (genvar g = 0; g < isa_pkg::LANES; g++) begin : g_lane
    isa_mul u_mul (
      .clk  (clk),
      .en   (mul_en),
      .x    (mx[g]),
      .y    (my[g]),
      .prod (prod[g])
    );
  end

  // side data: sums for the add kinds and flags for the bound merge
  always_comb begin
    logic [FW-1:0] addend_n, addend_u, addend_l;
    addend_n = s0_req.b_nominal;
    addend_u = s0_req.b_upper;
    addend_l = s0_req.b_lower;
    if (s0_req.kind == isa_pkg::KIND_ADD_CONST) begin
      addend_n = s0_req.scalar;
      addend_u = s0_req.scalar;
      addend_l = s0_req.scalar;
    end
    side_next.kind     = s0_req.kind;
    side_next.straddle = (s0_req.a_lower[FW-1] || (s0_req.a_lower == '0))
                         && !s0_req.a_upper[FW-1];
    side_next.sc_neg   = s0_req.scalar[FW-1];
    side_next.sum_n    = {s0_req.a_nominal[FW-1], s0_req.a_nominal}
                         + {addend_n[FW-1], addend_n};
    side_next.sum_u    = {s0_req.a_upper[FW-1], s0_req.a_upper}
                         + {addend_u[FW-1], addend_u};
    side_next.sum_l    = {s0_req.a_lower[FW-1], s0_req.a_lower}
                         + {addend_l[FW-1], addend_l};
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side[1] <= side_next;
    end
    for (int i = 2; i <= 5; i++) begin
      if (rdy[i]) begin
        side[i] <= side[i-1];
      end
    end
  end

  // stage 4: first level of the bound merge
  always_comb begin
    hi12_next = prod[1];
    lo12_next = prod[2];
    if ((side[3].kind == isa_pkg::KIND_MUL) || (side[3].kind == isa_pkg::KIND_SQUARE)) begin
      hi12_next = wmax(prod[1], prod[2]);
      lo12_next = wmin(prod[1], prod[2]);
    end else if (side[3].sc_neg) begin
      hi12_next = prod[2];
      lo12_next = prod[1];
    end
    mx34_next = wmax(prod[3], prod[4]);
    mn34_next = wmin(prod[3], prod[4]);
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      hi12 <= hi12_next;
      lo12 <= lo12_next;
      mx34 <= mx34_next;
      mn34 <= mn34_next;
      nom4 <= prod[0];
    end
  end

  // stage 5: second level
  always_comb begin
    up5_next = hi12;
    lo5_next = lo12;
    case (side[4].kind)
      isa_pkg::KIND_MUL: begin
        up5_next = wmax(hi12, mx34);
        lo5_next = wmin(lo12, mn34);
      end
      isa_pkg::KIND_SQUARE: begin
        if (side[4].straddle) begin
          lo5_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      up5  <= up5_next;
      lo5  <= lo5_next;
      nom5 <= nom4;
    end
  end

  // stage 6: merge with the nominal product, pick the result per kind
  always_comb begin
    s6_next  = '0;
    rs6_next = 1'b0;
    case (side[5].kind)
      isa_pkg::KIND_ADD, isa_pkg::KIND_ADD_CONST: begin
        s6_next.n = {{(WW - FW - 1){side[5].sum_n[FW]}}, side[5].sum_n};
        s6_next.u = {{(WW - FW - 1){side[5].sum_u[FW]}}, side[5].sum_u};
        s6_next.l = {{(WW - FW - 1){side[5].sum_l[FW]}}, side[5].sum_l};
      end
      isa_pkg::KIND_MUL, isa_pkg::KIND_SQUARE: begin
        s6_next.n = nom5;
        s6_next.u = wmax(up5, nom5);
        s6_next.l = wmin(lo5, nom5);
        rs6_next  = 1'b1;
      end
      isa_pkg::KIND_MUL_CONST_RS: begin
        s6_next.n = nom5;
        s6_next.u = up5;
        s6_next.l = lo5;
        rs6_next  = 1'b1;
      end
      isa_pkg::KIND_MUL_CONST: begin
        s6_next.n = nom5;
        s6_next.u = up5;
        s6_next.l = lo5;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6  <= s6_next;
      rs6 <= rs6_next;
    end
  end

  // stage 7: rescale shift
  always_comb begin
    s7_next = s6;
    if (rs6) begin
      s7_next.n = s6.n >>> scale_log2;
      s7_next.u = s6.u >>> scale_log2;
      s7_next.l = s6.l >>> scale_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7  <= s7_next;
      rs7 <= rs6;
    end
  end

  // stage 8: widen the bounds by the rescale error
  always_comb begin
    logic signed [WW-1:0] err_ext;
    err_ext = {{(WW - isa_pkg::ERR_W){1'b0}}, rescale_error};
    s8_next = s7;
    if (rs7) begin
      s8_next.u = s7.u + err_ext;
      s8_next.l = s7.l - err_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8 <= s8_next;
    end
  end

  // stage 9: saturate and hold the result
  always_comb begin
    logic signed [WW-1:0] n_sat, u_sat, l_sat;
    n_sat                = wsat(s8.n);
    u_sat                = wsat(s8.u);
    l_sat                = wsat(s8.l);
    res_next.res_nominal = n_sat[FW-1:0];
    res_next.res_upper   = u_sat[FW-1:0];
    res_next.res_lower   = l_sat[FW-1:0];
    res_next.saturated   = out_of_range(s8.n) || out_of_range(s8.u)
                           || out_of_range(s8.l);
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      res <= res_next;
    end
  end

endmodule
